FILE: rtl/core/htt_pkg.sv
package htt_pkg;

  localparam int FIELD_STATE_W = 16;
  localparam int SYMBOL_W      = 8;
  localparam int LIMIT_W       = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_SET    = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UPDATED = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic                       kind;
    logic [FIELD_STATE_W-1:0]   source_state;
    logic signed [SYMBOL_W-1:0] symbol;
    logic [FIELD_STATE_W-1:0]   target_state;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic [FIELD_STATE_W-1:0] next_state;
    logic [1:0]               status;
  } rsp_t;

endpackage

FILE: rtl/core/htt_ram.sv
module htt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/htt_hash.sv
module htt_hash import htt_pkg::*; #(
  parameter int BUCKET_BITS = 10,
  parameter int SRC_W       = 16
) (
  input  logic [SRC_W-1:0]           src,
  input  logic signed [SYMBOL_W-1:0] symbol,
  output logic [BUCKET_BITS-1:0]     bucket
);

  // wide enough for src*31 plus sign, and for the folded upper slice
  localparam int HW = (SRC_W + 6 > 2 * BUCKET_BITS) ? SRC_W + 6 : 2 * BUCKET_BITS;

  logic signed [HW-1:0] src_x;
  logic signed [HW-1:0] sym_x;
  logic signed [HW-1:0] h;
  logic signed [HW-1:0] h_sh;

  assign src_x = $signed({{(HW-SRC_W){1'b0}}, src});
  assign sym_x = $signed({{(HW-SYMBOL_W){symbol[SYMBOL_W-1]}}, symbol});

  // src*31 as a shift and subtract
  assign h    = (src_x <<< 5) - src_x + sym_x;
  assign h_sh = h >>> BUCKET_BITS;

  assign bucket = h[BUCKET_BITS-1:0] ^ h_sh[BUCKET_BITS-1:0];

endmodule

FILE: rtl/core/hashed_transition_table.sv
// Transition table of a pattern-matching automaton held as a chained hash table.
// Requests arrive on req (valid/ready): kind selects lookup or set of the
// transition (source_state, symbol). One response per request leaves on rsp
// (valid/ready): found and next_state for a lookup, status for a set.
// limit_we/limit_wdata write node_limit, the number of pool nodes that may be
// allocated; write it only while the table is idle.
// After the request transfer the item passes through ST_HEAD_RD, ST_HEAD, an ST_NODE
// step for each chain node read before a match or the end of the bucket chain, and
// ST_RESOLVE, which registers the response; a new request is taken back in ST_IDLE.
// The walk goes through one node-store read port, one node per cycle, so one
// item is in flight at a time and req_ready is high only when idle.
// After reset all 2**BUCKET_BITS bucket heads are swept to empty, one bucket a cycle,
// with req_ready low.
// Configuration writes are taken during the sweep.
// The response sits in an output register; if the receiver stalls, the final
// step of the next item holds until that register is free.
module hashed_transition_table import htt_pkg::*; #(
  parameter int BUCKET_BITS = 10,
  parameter int NODE_COUNT  = 4096,
  parameter int STATE_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               limit_we,
  input  logic [LIMIT_W-1:0] limit_wdata
);

  localparam int SW      = (STATE_BITS < FIELD_STATE_W) ? STATE_BITS : FIELD_STATE_W;
  localparam int NW      = $clog2(NODE_COUNT);
  localparam int PW      = NW + 1;                 // node index plus one, 0 = end of chain
  localparam int BUCKETS = 1 << BUCKET_BITS;
  localparam int CW      = (PW > LIMIT_W) ? PW : LIMIT_W;

  typedef struct packed {
    logic [SW-1:0]       src;
    logic [SYMBOL_W-1:0] sym;
    logic [SW-1:0]       tgt;
    logic [PW-1:0]       link;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_HEAD_RD = 6'b000100,
    ST_HEAD    = 6'b001000,
    ST_NODE    = 6'b010000,
    ST_RESOLVE = 6'b100000
  } state_t;

  state_t                 st, st_next;
  logic [BUCKET_BITS-1:0] clr_addr;
  req_t                   item;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [PW-1:0]          head_q;
  logic [NW-1:0]          cur;
  logic                   hit;
  logic [SW-1:0]          hit_tgt;
  logic [PW-1:0]          hit_link;
  logic [PW-1:0]          nodes_used;
  logic [LIMIT_W-1:0]     node_limit;

  logic [BUCKET_BITS-1:0] req_bucket;

  // bucket-head memory
  logic                   head_we;
  logic [BUCKET_BITS-1:0] head_waddr;
  logic [PW-1:0]          head_wdata;
  logic                   head_re;
  logic [PW-1:0]          head_rdata;

  // node store
  logic                   node_we;
  logic [NW-1:0]          node_waddr;
  node_t                  node_wdata;
  logic                   node_re;
  logic [NW-1:0]          node_raddr;
  logic [NODE_W-1:0]      node_rdata;
  node_t                  rd_node;

  logic [PW-1:0]          head_dec;
  logic [PW-1:0]          link_dec;
  logic                   match;
  logic [CW-1:0]          lim_ext;
  logic [CW-1:0]          lim;
  logic                   full;
  logic                   slot_free;
  logic                   finish;
  logic                   do_insert;
  logic                   do_update;

  htt_hash #(
    .BUCKET_BITS (BUCKET_BITS),
    .SRC_W       (SW)
  ) u_hash (
    .src    (req.source_state[SW-1:0]),
    .symbol (req.symbol),
    .bucket (req_bucket)
  );

  htt_ram #(
    .WIDTH (PW),
    .DEPTH (BUCKETS)
  ) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (bucket_q),
    .rdata (head_rdata)
  );

  htt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign rd_node   = node_t'(node_rdata);
  assign head_dec  = head_rdata - 1'b1;
  assign link_dec  = rd_node.link - 1'b1;
  assign match     = (rd_node.src == item.source_state[SW-1:0]) &&
                     (rd_node.sym == item.symbol);

  // effective limit: the configured count, capped at the pool size
  assign lim_ext   = CW'(node_limit);
  assign lim       = (lim_ext > CW'(NODE_COUNT)) ? CW'(NODE_COUNT) : lim_ext;
  assign full      = CW'(nodes_used) >= lim;

  assign req_ready = (st == ST_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;
  assign finish    = (st == ST_RESOLVE) && slot_free;
  assign do_update = finish && (item.kind == KIND_SET) && hit;
  assign do_insert = finish && (item.kind == KIND_SET) && !hit && !full;

  // sequencer and memory port control
  always_comb begin
    st_next    = st;
    head_we    = 1'b0;
    head_waddr = clr_addr;
    head_wdata = '0;
    head_re    = 1'b0;
    node_re    = 1'b0;
    node_raddr = cur;
    node_we    = 1'b0;
    node_waddr = cur;
    node_wdata = '0;
    case (st)
      ST_CLEAR: begin
        head_we = 1'b1;
        if (&clr_addr) begin
          st_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          st_next = ST_HEAD_RD;
        end
      end
      ST_HEAD_RD: begin
        head_re = 1'b1;
        st_next = ST_HEAD;
      end
      ST_HEAD: begin
        if (head_rdata == '0) begin
          st_next = ST_RESOLVE;
        end else begin
          node_re    = 1'b1;
          node_raddr = head_dec[NW-1:0];
          st_next    = ST_NODE;
        end
      end
      ST_NODE: begin
        if (match || rd_node.link == '0) begin
          st_next = ST_RESOLVE;
        end else begin
          node_re    = 1'b1;
          node_raddr = link_dec[NW-1:0];
        end
      end
      ST_RESOLVE: begin
        if (slot_free) begin
          st_next = ST_IDLE;
        end
        // overwrite the target of the matching node in place
        if (do_update) begin
          node_we    = 1'b1;
          node_waddr = cur;
          node_wdata = '{src: item.source_state[SW-1:0], sym: item.symbol,
                         tgt: item.target_state[SW-1:0], link: hit_link};
        end
        // prepend a fresh pool node to the bucket chain
        if (do_insert) begin
          node_we    = 1'b1;
          node_waddr = nodes_used[NW-1:0];
          node_wdata = '{src: item.source_state[SW-1:0], sym: item.symbol,
                         tgt: item.target_state[SW-1:0], link: head_q};
          head_we    = 1'b1;
          head_waddr = bucket_q;
          head_wdata = nodes_used + 1'b1;
        end
      end
      default: begin
        st_next = ST_CLEAR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_CLEAR;
      clr_addr   <= '0;
      nodes_used <= '0;
      node_limit <= LIMIT_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (limit_we) begin
        node_limit <= limit_wdata;
      end
      if (do_insert) begin
        nodes_used <= nodes_used + 1'b1;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // item and walk payload
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item     <= req;
      bucket_q <= req_bucket;
    end
    if (st == ST_HEAD) begin
      head_q <= head_rdata;
      hit    <= 1'b0;
    end
    if (node_re) begin
      cur <= node_raddr;
    end
    if (st == ST_NODE && match) begin
      hit      <= 1'b1;
      hit_tgt  <= rd_node.tgt;
      hit_link <= rd_node.link;
    end
    if (finish) begin
      rsp.found      <= (item.kind == KIND_LOOKUP) && hit;
      rsp.next_state <= ((item.kind == KIND_LOOKUP) && hit) ?
                        FIELD_STATE_W'(hit_tgt) : '0;
      if (item.kind == KIND_SET) begin
        rsp.status <= hit ? STATUS_UPDATED : (full ? STATUS_FULL : STATUS_OK);
      end else begin
        rsp.status <= STATUS_OK;
      end
    end
  end

  // pool never grows past its size
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= PW'(NODE_COUNT))
    else $error("node pool count exceeds pool size");

  // pool advances by at most one node per cycle
  a_pool_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (nodes_used == $past(nodes_used)) ||
             (nodes_used == $past(nodes_used) + 1'b1))
    else $error("node pool count jumped");

  // a chain walk only reads nodes already allocated
  a_walk_alloc: assert property (@(posedge clk) disable iff (rst)
    st == ST_NODE |-> {1'b0, cur} < nodes_used)
    else $error("chain walk reached an unallocated node");

  // no response before the bucket sweep is done; found only with plain status
  a_rsp_sane: assert property (@(posedge clk) disable iff (rst)
    (st != ST_CLEAR || !rsp_valid) &&
    (!(rsp_valid && rsp.found) || rsp.status == STATUS_OK))
    else $error("response inconsistent with table state");

endmodule
